[hdl/fbfl_pkg.sv]
// shared constants, codes and command/status types for the block pool allocator
// no dependencies; imported by every module of the allocator
package fbfl_pkg;

  // pool geometry
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W      = LINK_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

  // stream field widths
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic                rd_head;    // start link read at the head
    logic                pop;        // head takes the link read back
    logic                push;       // link freed block in front of head
    logic                init_step;  // write one link of the rebuild walk
    logic                init_done;  // head to block 0, count to pool size
    logic                load;       // load the result register
    logic                grant;      // result carries the old head
    logic [STATUS_W-1:0] status;     // result status code
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic can_pop;
    logic can_push;
    logic init_last;
  } sts_t;

endpackage

[hdl/fbfl_dp.sv]
// datapath: link memory, head and count registers, rebuild counter, result register
// depends on fbfl_pkg
module fbfl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [fbfl_pkg::CNT_W-1:0]    cfg_data,
  input  logic [fbfl_pkg::IDX_W-1:0]    block_index,
  input  fbfl_pkg::cmd_t                cmd,
  output fbfl_pkg::sts_t                sts,
  output logic [fbfl_pkg::STATUS_W-1:0] res_status,
  output logic [fbfl_pkg::IDX_W-1:0]    res_granted,
  output logic [fbfl_pkg::CNT_W-1:0]    res_count
);
  import fbfl_pkg::*;

  logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0] rd_data;
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  pool_blocks;
  logic [CNT_W-1:0]  pool_n;
  logic [CNT_W-1:0]  pool_last;
  logic [IDX_W-1:0]  init_ctr;
  logic              init_last;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LINK_W-1:0] wr_data;

  // effective pool size, zero acts as one and large values saturate
  always_comb begin
    if (pool_blocks == '0) begin
      pool_n = CNT_W'(1);
    end else if (pool_blocks > CNT_W'(MAX_BLOCKS)) begin
      pool_n = CNT_W'(MAX_BLOCKS);
    end else begin
      pool_n = pool_blocks;
    end
  end

  assign pool_last = pool_n - CNT_W'(1);
  assign init_last = (init_ctr == pool_last[IDX_W-1:0]);

  // status back to the controller
  assign sts.can_pop   = (count != '0) && (head < NULL_LINK);
  assign sts.can_push  = (count < pool_n);
  assign sts.init_last = init_last;

  // link memory write port, shared by free and rebuild
  always_comb begin
    wr_en   = cmd.push | cmd.init_step;
    wr_addr = cmd.push ? block_index : init_ctr;
    if (cmd.push) begin
      wr_data = head;
    end else if (init_last) begin
      wr_data = NULL_LINK;
    end else begin
      wr_data = LINK_W'(init_ctr) + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  // registered read of the link behind the head
  always_ff @(posedge clk) begin
    if (cmd.rd_head) begin
      rd_data <= link_mem[head[IDX_W-1:0]];
    end
  end

  // head and count update
  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.push) begin
      head_next  = LINK_W'(block_index);
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      head_next  = rd_data;
      count_next = count - CNT_W'(1);
    end else if (cmd.init_done) begin
      head_next  = '0;
      count_next = pool_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= NULL_LINK;
      count       <= '0;
      init_ctr    <= '0;
      pool_blocks <= CNT_W'(MAX_BLOCKS);
    end else begin
      head  <= head_next;
      count <= count_next;
      if (cmd.init_done) begin
        init_ctr <= '0;
      end else if (cmd.init_step) begin
        init_ctr <= init_ctr + IDX_W'(1);
      end
      if (cfg_wr) begin
        pool_blocks <= cfg_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status  <= cmd.status;
      res_granted <= cmd.grant ? head[IDX_W-1:0] : '0;
      res_count   <= count_next;
    end
  end

endmodule

[hdl/fbfl_ctrl.sv]
// controller: sequences allocate, free and rebuild and owns the output valid
// depends on fbfl_pkg
module fbfl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fbfl_pkg::KIND_W-1:0] kind,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  fbfl_pkg::sts_t              sts,
  output fbfl_pkg::cmd_t              cmd
);
  import fbfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // take a new item only when idle and the result slot is free or draining
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_ALLOC: begin
              if (sts.can_pop) begin
                cmd.rd_head = 1'b1;
                state_next  = S_POP;
              end else begin
                cmd.load   = 1'b1;
                cmd.status = ST_EMPTY;
              end
            end
            KIND_FREE: begin
              cmd.load = 1'b1;
              if (sts.can_push) begin
                cmd.push   = 1'b1;
                cmd.status = ST_DONE;
              end else begin
                cmd.status = ST_FULL;
              end
            end
            KIND_INIT: begin
              state_next = S_INIT;
            end
            default: begin
              cmd.load   = 1'b1;
              cmd.status = ST_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        cmd.load   = 1'b1;
        cmd.grant  = 1'b1;
        cmd.status = ST_DONE;
        state_next = S_IDLE;
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          cmd.init_done = 1'b1;
          cmd.load      = 1'b1;
          cmd.status    = ST_DONE;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/fixed_block_free_list_allocator.sv]
// Fixed-size block pool allocator with a LIFO free list of block indices.
// Input stream: s_tuser carries the operation (allocate, free, rebuild),
// s_tdata the block index used by free. Every transaction gives exactly one
// result on the output stream: m_tuser the status (done, pool empty, pool
// full), m_tdata the granted index and the free count after the operation.
// Configuration: cfg_data sets the pool size used by rebuild and as the
// free limit; it is always ready and should be written while idle.
// Timing: free and failed operations give their result at the accepting
// edge; allocate passes through S_POP because the link memory read of
// the head must return before the new head is known; rebuild walks
// the pool in S_INIT, writing one link per cycle.
// One item is in flight at a time. While a result waits on m_tready no new
// transaction is accepted, and the result holds steady.
// Reset (rst, synchronous) empties the pool (head null, count zero) and
// sets the pool size to 256; link contents are only defined after rebuild.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_dp.
module fixed_block_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fbfl_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] block_index
  input  logic [fbfl_pkg::KIND_W-1:0]     s_tuser,   // [1:0] kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fbfl_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] granted_index, [16:8] free_count
  output logic [fbfl_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbfl_pkg::CNT_W-1:0]      cfg_data
);
  import fbfl_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [IDX_W-1:0]  res_granted;
  logic [CNT_W-1:0]  res_count;

  assign cfg_ready = 1'b1;

  // sequencing
  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and result
  fbfl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .block_index (s_tdata[IDX_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .res_status  (m_tuser),
    .res_granted (res_granted),
    .res_count   (res_count)
  );

  // pack result payload, zero fill to whole bytes
  assign m_tdata = {(OUT_DATA_W - IDX_W - CNT_W)'(0), res_count, res_granted};

endmodule

[hdl/fbfl_chk.sv]
// port-level checker for the block pool allocator, bound to the top level
// depends on fbfl_pkg and fixed_block_free_list_allocator
module fbfl_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fbfl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [fbfl_pkg::STATUS_W-1:0]   m_tuser
);
  import fbfl_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no new transaction while a result is stalled
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input ready while result stalled");

  // only known status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_DONE) || (m_tuser == ST_EMPTY) || (m_tuser == ST_FULL))
    else $error("unknown status code");

  // failed operations grant nothing
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata[IDX_W-1:0] == '0))
    else $error("grant on failed operation");

  // free count never exceeds the maximum pool size
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[IDX_W+CNT_W-1:IDX_W] <= CNT_W'(MAX_BLOCKS)))
    else $error("free count beyond pool");

endmodule

bind fixed_block_free_list_allocator fbfl_chk u_fbfl_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
